// ===== rtl/core/dfgs_pkg.sv =====
// Package: shared types, codes and defaults of the FR-FCFS grouping scheduler.
`timescale 1ns / 1ps
package dfgs_pkg;

    localparam int NUM_BANKS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SELECT = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  request_tag;
        logic [3:0]  bank;
        logic [17:0] row;
        logic [31:0] address;
        logic        is_write;
        logic        bank_open;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [7:0] chosen_tag;
        logic       further_row_hit;
        logic       further_request;
    } t_res;

    typedef struct packed {
        logic [7:0]  tag;
        logic [17:0] row;
        logic [31:0] addr;
        logic        wr;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_entry wdata;
    } t_ram_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_HAZ_RD,
        S_HAZ_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FIN_RD,
        S_FIN
    } t_state;

endpackage

// ===== rtl/core/dfgs_entry_ram.sv =====
// Request entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module dfgs_entry_ram #(
    parameter int AW = 7
) (
    input  logic                i_clk,
    input  dfgs_pkg::t_ram_wr   i_wr,
    input  logic [AW-1:0]       i_waddr,
    input  logic [AW-1:0]       i_raddr,
    output dfgs_pkg::t_entry    o_rdata
);
    import dfgs_pkg::*;

    t_entry r_mem [2**AW];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dram_frfcfs_grouping_scheduler.sv =====
// Top level: per-bank FR-FCFS request queues with read/write grouping.
//
//  channel | ports                 | handshake
//  --------+-----------------------+------------------------------------
//  command | i_cmd                 | taken when start is high, busy low
//  result  | o_res                 | valid for one cycle while o_strobe
//
// Store writes the entry at dispatch; query and remove scan the bank's entries
// in order, remove then shifting later entries down. Select scans entries; each
// same-command row hit adds a hazard rescan of the earlier entries.
// One shared entry memory port and one compare unit serialise these scans.
// Reset empties every queue through the occupancy counters; no clearing pass.
// The result cannot be stalled; busy stays high until the result is shown.
`timescale 1ns / 1ps
module dram_frfcfs_grouping_scheduler #(
    parameter int NUM_BANKS   = dfgs_pkg::NUM_BANKS_DEF,
    parameter int QUEUE_DEPTH = dfgs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  dfgs_pkg::t_cmd  i_cmd,
    output logic            o_strobe,
    output dfgs_pkg::t_res  o_res
);
    import dfgs_pkg::*;

    localparam int AW = (NUM_BANKS * QUEUE_DEPTH > 2) ? $clog2(NUM_BANKS * QUEUE_DEPTH) : 1;
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [AW-1:0]   r_base, n_base;
    logic [BW-1:0]   r_bidx, n_bidx;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [IW-1:0]   r_ridx, n_ridx;
    logic [IW-1:0]   r_ci, n_ci;
    logic [IW-1:0]   r_first, n_first;
    logic            r_first_v, n_first_v;
    logic [31:0]     r_cand_addr, n_cand_addr;
    logic [7:0]      r_cand_tag, n_cand_tag;
    logic [1:0]      r_hits, n_hits;
    logic            r_last_wr, n_last_wr;
    logic            r_strobe, n_strobe;
    t_res            r_res, n_res;
    logic [CW-1:0]   r_occ [NUM_BANKS];
    logic            occ_we;
    logic [CW-1:0]   occ_val;

    t_ram_wr         ram_wr;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    t_entry          rdata;

    logic            bank_ok;
    logic [CW-1:0]   ridx_nx;
    logic            row_hit;

    dfgs_entry_ram #(.AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_waddr (ram_waddr),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    assign bank_ok   = 32'(i_cmd.bank) < NUM_BANKS;
    assign ram_raddr = r_base + AW'(r_ridx);
    assign ridx_nx   = CW'(r_ridx) + CW'(1);
    assign row_hit   = rdata.row == r_cmd.row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_last_wr <= 1'b0;
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_occ[b] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_last_wr <= n_last_wr;
            if (occ_we) begin
                r_occ[r_bidx] <= occ_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_base      <= n_base;
        r_bidx      <= n_bidx;
        r_cnt       <= n_cnt;
        r_ridx      <= n_ridx;
        r_ci        <= n_ci;
        r_first     <= n_first;
        r_first_v   <= n_first_v;
        r_cand_addr <= n_cand_addr;
        r_cand_tag  <= n_cand_tag;
        r_hits      <= n_hits;
        r_res       <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_base      = r_base;
        n_bidx      = r_bidx;
        n_cnt       = r_cnt;
        n_ridx      = r_ridx;
        n_ci        = r_ci;
        n_first     = r_first;
        n_first_v   = r_first_v;
        n_cand_addr = r_cand_addr;
        n_cand_tag  = r_cand_tag;
        n_hits      = r_hits;
        n_last_wr   = r_last_wr;
        n_res       = r_res;
        n_strobe    = 1'b0;
        occ_we      = 1'b0;
        occ_val     = r_cnt;
        ram_wr.we   = 1'b0;
        ram_wr.wdata = '{tag: r_cmd.request_tag, row: r_cmd.row,
                         addr: r_cmd.address, wr: r_cmd.is_write};
        ram_waddr   = r_base + AW'(r_cnt);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_bidx    = BW'(i_cmd.bank);
                    n_base    = AW'(32'(i_cmd.bank) * QUEUE_DEPTH);
                    n_cnt     = bank_ok ? r_occ[BW'(i_cmd.bank)] : '0;
                    n_ridx    = '0;
                    n_first_v = 1'b0;
                    n_first   = '0;
                    n_hits    = '0;
                    n_res     = '0;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_cmd.operation)
                    OP_STORE: begin
                        if (r_cnt == '0 && 32'(r_cmd.bank) >= NUM_BANKS ||
                            32'(r_cnt) >= QUEUE_DEPTH) begin
                            n_res.status = ST_FULL;
                        end else begin
                            ram_wr.we = 1'b1;
                            occ_we    = 1'b1;
                            occ_val   = r_cnt + CW'(1);
                        end
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                    OP_REMOVE: begin
                        n_last_wr = r_cmd.is_write;
                        if (r_cnt == '0) begin
                            n_res.status = ST_NONE;
                            n_strobe     = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    OP_SELECT: begin
                        if (r_cnt == '0) begin
                            n_res.status = ST_NONE;
                            n_strobe     = 1'b1;
                            n_state      = S_IDLE;
                        end else if (!r_cmd.bank_open) begin
                            n_state = S_FIN_RD;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    OP_QUERY: begin
                        if (r_cnt == '0) begin
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                n_state = S_SCAN_RD;
                n_ridx  = IW'(ridx_nx);
                unique case (r_cmd.operation)
                    OP_REMOVE: begin
                        if (rdata.tag == r_cmd.request_tag) begin
                            if (ridx_nx < r_cnt) begin
                                n_state = S_SHIFT_RD;
                            end else begin
                                occ_we       = 1'b1;
                                occ_val      = r_cnt - CW'(1);
                                n_res.found  = 1'b1;
                                n_strobe     = 1'b1;
                                n_state      = S_IDLE;
                            end
                        end else if (!(ridx_nx < r_cnt)) begin
                            n_res.status = ST_NONE;
                            n_strobe     = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_QUERY: begin
                        if (row_hit && r_hits != 2'd2) begin
                            n_hits = r_hits + 2'd1;
                        end
                        if (!(ridx_nx < r_cnt)) begin
                            n_res.further_row_hit = (row_hit && r_hits != 2'd0) ||
                                                    r_hits == 2'd2;
                            n_res.further_request = r_cnt >= CW'(2);
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    default: begin
                        // select with the bank open
                        if (row_hit && !r_first_v) begin
                            n_first_v = 1'b1;
                            n_first   = r_ridx;
                        end
                        if (row_hit && rdata.wr == r_last_wr && r_ridx == '0) begin
                            n_res.found      = 1'b1;
                            n_res.chosen_tag = rdata.tag;
                            n_strobe         = 1'b1;
                            n_state          = S_IDLE;
                        end else if (row_hit && rdata.wr == r_last_wr) begin
                            // check earlier hits for the same address
                            n_ci        = r_ridx;
                            n_cand_addr = rdata.addr;
                            n_cand_tag  = rdata.tag;
                            n_ridx      = '0;
                            n_state     = S_HAZ_RD;
                        end else if (!(ridx_nx < r_cnt)) begin
                            n_ridx  = (r_first_v || row_hit) ?
                                      (r_first_v ? r_first : r_ridx) : '0;
                            n_state = S_FIN_RD;
                        end
                    end
                endcase
            end
            S_HAZ_RD: n_state = S_HAZ_CHK;
            S_HAZ_CHK: begin
                if (row_hit && rdata.addr == r_cand_addr) begin
                    // hazard: resume the scan after the candidate
                    if (CW'(r_ci) + CW'(1) < r_cnt) begin
                        n_ridx  = r_ci + IW'(1);
                        n_state = S_SCAN_RD;
                    end else begin
                        n_ridx  = r_first;
                        n_state = S_FIN_RD;
                    end
                end else if (ridx_nx < CW'(r_ci)) begin
                    n_ridx  = IW'(ridx_nx);
                    n_state = S_HAZ_RD;
                end else begin
                    n_res.found      = 1'b1;
                    n_res.chosen_tag = r_cand_tag;
                    n_strobe         = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: begin
                ram_wr.we    = 1'b1;
                ram_wr.wdata = rdata;
                ram_waddr    = r_base + AW'(r_ridx) - AW'(1);
                if (ridx_nx < r_cnt) begin
                    n_ridx  = IW'(ridx_nx);
                    n_state = S_SHIFT_RD;
                end else begin
                    occ_we      = 1'b1;
                    occ_val     = r_cnt - CW'(1);
                    n_res.found = 1'b1;
                    n_strobe    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_FIN_RD: n_state = S_FIN;
            S_FIN: begin
                n_res.found      = 1'b1;
                n_res.chosen_tag = rdata.tag;
                n_strobe         = 1'b1;
                n_state          = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy     = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");
    a_strobe_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy && $past(busy))
        else $error("result strobe without finished work");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.found |-> o_res.status == ST_OK)
        else $error("found with bad status");
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_we |-> 32'(occ_val) <= QUEUE_DEPTH)
        else $error("bank occupancy overflow");

endmodule

// ===== verif/tb_dram_frfcfs_grouping_scheduler.sv =====
// Testbench: random and directed command items checked against a per-bank queue predictor.
`timescale 1ns / 1ps
module tb_dram_frfcfs_grouping_scheduler;
    import dfgs_pkg::*;

    localparam int NB = NUM_BANKS_DEF;
    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_cmd i_cmd = '0;
    logic o_strobe;
    t_res o_res;

    dram_frfcfs_grouping_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_strobe(o_strobe), .o_res(o_res)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    t_entry bank_q [NB][QD];
    int     bank_cnt [NB];
    logic   last_wr;

    t_cmd pending_cmds [$];
    t_res expected_res [$];
    int   err_count = 0;
    int   cycle_count = 0;
    int   idle_left = 0;
    bit   idle_enable = 1'b1;
    bit   hold_sender = 1'b0;
    logic [7:0] live_tags [NB][$];

    task automatic report(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic enqueue_cmd(input t_cmd c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    function automatic t_res schedule_step(input t_cmd c);
        t_res r;
        int b, cnt, pick, first_hit, hits;
        bit haz;
        r = '0;
        b = c.bank;
        cnt = bank_cnt[b];
        case (c.operation)
            OP_STORE: begin
                if (cnt >= QD) begin
                    r.status = ST_FULL;
                end else begin
                    bank_q[b][cnt] = '{tag: c.request_tag, row: c.row, addr: c.address,
                                       wr: c.is_write};
                    bank_cnt[b] = cnt + 1;
                    r.status = ST_OK;
                end
            end
            OP_REMOVE: begin
                last_wr = c.is_write;
                r.status = ST_NONE;
                for (int i = 0; i < cnt; i++) begin
                    if (bank_q[b][i].tag == c.request_tag) begin
                        for (int j = i; j + 1 < cnt; j++) bank_q[b][j] = bank_q[b][j+1];
                        bank_q[b][cnt-1] = '0;
                        bank_cnt[b] = cnt - 1;
                        r.status = ST_OK;
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            OP_SELECT: begin
                if (cnt == 0) begin
                    r.status = ST_NONE;
                end else begin
                    pick = -1;
                    first_hit = -1;
                    if (c.bank_open) begin
                        for (int i = 0; i < cnt && pick < 0; i++) begin
                            if (bank_q[b][i].row != c.row) continue;
                            if (first_hit < 0) first_hit = i;
                            if (bank_q[b][i].wr != last_wr) continue;
                            haz = 1'b0;
                            for (int j = 0; j < i; j++)
                                if (bank_q[b][j].row == c.row &&
                                    bank_q[b][j].addr == bank_q[b][i].addr) haz = 1'b1;
                            if (!haz) pick = i;
                        end
                        if (pick < 0) pick = first_hit;
                    end
                    if (pick < 0) pick = 0;
                    r.status = ST_OK;
                    r.found = 1'b1;
                    r.chosen_tag = bank_q[b][pick].tag;
                end
            end
            default: begin
                hits = 0;
                for (int i = 0; i < cnt; i++) if (bank_q[b][i].row == c.row) hits++;
                r.status = ST_OK;
                r.further_row_hit = (hits >= 2);
                r.further_request = (cnt >= 2);
            end
        endcase
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_res.insert(expected_res.size(), schedule_step(i_cmd));
                void'(pending_cmds.pop_front());
            end
            if (start && busy) begin
                // hold the item until taken
            end else if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                start <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
                idle_left <= $urandom_range(1, 16) - 1;
                start <= 1'b0;
            end else if (hold_sender) begin
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                i_cmd <= pending_cmds[0];
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) begin
            if (expected_res.size() == 0) begin
                report("result with no item outstanding");
            end else begin
                e = expected_res.pop_front();
                if (o_res.status !== e.status)
                    report($sformatf("status %0d exp %0d", o_res.status, e.status));
                if (o_res.found !== e.found)
                    report($sformatf("found %0b exp %0b", o_res.found, e.found));
                if (o_res.chosen_tag !== e.chosen_tag)
                    report($sformatf("tag %0d exp %0d", o_res.chosen_tag, e.chosen_tag));
                if (o_res.further_row_hit !== e.further_row_hit)
                    report($sformatf("row_hit %0b exp %0b", o_res.further_row_hit,
                                     e.further_row_hit));
                if (o_res.further_request !== e.further_request)
                    report($sformatf("further_req %0b exp %0b", o_res.further_request,
                                     e.further_request));
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout");
            $display("tb_dram_frfcfs_grouping_scheduler: errors");
            $finish;
        end
    end

    function automatic t_cmd mk(input logic [1:0] op, input logic [7:0] tg,
                                input logic [3:0] bk, input logic [17:0] rw,
                                input logic [31:0] ad, input logic wr, input logic bo);
        t_cmd c;
        c.operation = op; c.request_tag = tg; c.bank = bk; c.row = rw;
        c.address = ad; c.is_write = wr; c.bank_open = bo;
        return c;
    endfunction

    // random item biased toward a few rows, addresses and live tags
    function automatic t_cmd rand_cmd();
        t_cmd c;
        int k;
        logic [3:0] bk;
        bk = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        c = mk(2'($urandom), 8'($urandom), bk,
               ($urandom_range(0, 4) == 0) ? 18'($urandom) : 18'($urandom_range(0, 2)),
               ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 3)),
               1'($urandom), 1'($urandom));
        if (c.operation == OP_REMOVE && live_tags[bk].size() > 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, live_tags[bk].size() - 1);
            c.request_tag = live_tags[bk][k];
            live_tags[bk].delete(k);
        end else if (c.operation == OP_STORE) begin
            if ($urandom_range(0, 2) == 0) c.request_tag = 8'($urandom_range(0, 7));
            live_tags[bk].insert(live_tags[bk].size(), c.request_tag);
        end
        return c;
    endfunction

    task automatic wait_drain();
        while (pending_cmds.size() > 0 || start || expected_res.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        for (int b = 0; b < NB; b++) begin
            bank_cnt[b] = 0;
            for (int i = 0; i < QD; i++) bank_q[b][i] = '0;
        end
        last_wr = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty bank ops, fill bank 15 past full, grouping and hazard checks
        enqueue_cmd(mk(OP_SELECT, 8'h00, 4'd15, 18'h3FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        enqueue_cmd(mk(OP_REMOVE, 8'hFF, 4'd15, '0, '0, 1'b1, 1'b0));
        enqueue_cmd(mk(OP_QUERY, 8'h00, 4'd15, 18'h3FFFF, '0, 1'b0, 1'b0));
        for (int i = 0; i < QD + 1; i++)
            enqueue_cmd(mk(OP_STORE, 8'(i + 1), 4'd15, (i < 4) ? 18'h3FFFF : 18'd0,
                           (i % 2) ? 32'hFFFF_FFFF : 32'd0, 1'(i % 3 == 0), 1'b0));
        enqueue_cmd(mk(OP_QUERY, 8'h00, 4'd15, 18'h3FFFF, '0, 1'b0, 1'b0));
        enqueue_cmd(mk(OP_SELECT, 8'h00, 4'd15, 18'h3FFFF, '0, 1'b0, 1'b1));
        enqueue_cmd(mk(OP_SELECT, 8'h00, 4'd15, 18'h3FFFF, '0, 1'b0, 1'b0));
        enqueue_cmd(mk(OP_SELECT, 8'h00, 4'd15, 18'h12345, '0, 1'b0, 1'b1));
        enqueue_cmd(mk(OP_REMOVE, 8'd1, 4'd15, '0, '0, 1'b0, 1'b0));
        enqueue_cmd(mk(OP_SELECT, 8'h00, 4'd15, 18'd0, '0, 1'b0, 1'b1));
        enqueue_cmd(mk(OP_STORE, 8'd2, 4'd15, 18'd0, 32'd5, 1'b1, 1'b0));
        enqueue_cmd(mk(OP_REMOVE, 8'd2, 4'd15, '0, '0, 1'b1, 1'b0));
        enqueue_cmd(mk(OP_QUERY, 8'h00, 4'd15, 18'd0, '0, 1'b0, 1'b0));
        wait_drain();

        // pause the sender mid-stream until every result is back
        for (int n = 0; n < 200; n++) enqueue_cmd(rand_cmd());
        while (pending_cmds.size() > 100) @(posedge i_clk);
        hold_sender = 1'b1;
        while (start || expected_res.size() > 0) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drain();
        for (int n = 0; n < 200; n++) enqueue_cmd(rand_cmd());
        wait_drain();
        idle_enable = 1'b0;
        for (int n = 0; n < 200; n++) enqueue_cmd(rand_cmd());
        wait_drain();
        repeat (300) @(posedge i_clk);
        if (err_count == 0 && expected_res.size() == 0) begin
            $display("tb_dram_frfcfs_grouping_scheduler: clean");
        end else begin
            $display("tb_dram_frfcfs_grouping_scheduler: errors");
        end
        $finish;
    end
endmodule

// ===== dram_frfcfs_grouping_scheduler.f =====
rtl/core/dfgs_pkg.sv
rtl/core/dfgs_entry_ram.sv
rtl/core/dram_frfcfs_grouping_scheduler.sv
verif/tb_dram_frfcfs_grouping_scheduler.sv
